// ===== rtl/core/sbb_pkg.sv =====
package sbb_pkg;
   localparam int MaxWidth  = 256;
   localparam int MaxHeight = 256;
   localparam int MaxRadius = 7;
   localparam int RingRows  = 2 * MaxRadius + 2;
   localparam int StoreDepth = RingRows * MaxWidth;
   localparam int AddrW  = $clog2(StoreDepth);
   localparam int RowW   = $clog2(RingRows);
   localparam int ColW   = $clog2(MaxWidth);
   localparam int CntW   = 17;
   localparam int SumW   = 16;
   localparam int DimW   = 9;
   localparam int RadW   = 3;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SUM, ST_LAST, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [SumW-1:0] dividend;
      logic [7:0] divisor;
   } div_req_type;
endpackage

// ===== rtl/core/sbb_div.sv =====
module sbb_div (
   input  logic clock,
   input  logic reset,
   input  sbb_pkg::div_req_type req,
   output logic done,
   output logic [7:0] quotient
);
   import sbb_pkg::*;
   logic [SumW-1:0] quo_ff, quo_in;
   logic [8:0] rem_ff, rem_in;
   logic [7:0] dvs_ff, dvs_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [9:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done = 1'b0;
      trial = {rem_ff, quo_ff[SumW-1]};
      if (req.start) begin
         quo_in = req.dividend; rem_in = '0; dvs_in = req.divisor;
         cnt_in = 5'(SumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {2'b0, dvs_ff}) begin
            rem_in = 9'(trial - {2'b0, dvs_ff});
            quo_in = {quo_ff[SumW-2:0], 1'b1};
         end else begin
            rem_in = trial[8:0];
            quo_in = {quo_ff[SumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end
   assign quotient = quo_in[7:0];

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end
endmodule

// ===== rtl/core/separable_box_blur_8bit.sv =====
// channel | ports                 | payload
// req     | req_tvalid/tready     | tdata[0]=opcode, tdata[8:1]=pixel_in
// rsp     | rsp_tvalid/tready     | tdata[7:0]=pixel_out, tlast=frame_last
// csr     | csr_we/index/wdata    | radius, frame_width, frame_height
// One item at a time. A pixel with no output due is taken and req_tready
// stays high. An output sums the window one store read a cycle (accept,
// (2r+1)^2 reads and a final add), then the restoring divider forms the
// mean and the result register holds it; a copied-through row takes one
// read and skips the divider. Reset is synchronous; the row store is not
// cleared (entries read are always written earlier in the frame). A held
// result blocks req.
module separable_box_blur_8bit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,  // opcode, pixel_in
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // pixel_out
   output logic rsp_tlast,         // frame_last
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_wdata
);
   import sbb_pkg::*;

   logic [7:0] mem [StoreDepth];
   logic [7:0] rd_ff;
   logic [AddrW-1:0] raddr;
   logic re, we;
   logic [AddrW-1:0] waddr;

   logic [RadW-1:0] rad_ff;
   logic [DimW-1:0] wid_ff, hgt_ff;
   logic [CntW-1:0] icnt_ff, icnt_in, ocnt_ff, ocnt_in;
   // raster position of input and output kept as row/col
   logic [DimW-1:0] iy_ff, iy_in, ix_ff, ix_in, oy_ff, oy_in, ox_ff, ox_in;
   logic [RowW-1:0] irow_ff, irow_in, orow_ff, orow_in;
   state_type st_ff, st_in;
   logic [3:0] dy_ff, dy_in, dx_ff, dx_in;
   logic [RowW-1:0] srow_ff, srow_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic pass_ff, pass_in, last_ff, last_in;
   logic [7:0] out_ff, out_in;
   logic vld_ff, vld_in;
   logic accept;
   logic [CntW-1:0] total, lag;
   logic [3:0] side;
   div_req_type dreq;
   logic ddone;
   logic [7:0] dq;
   logic [DimW:0] colx;
   logic [ColW-1:0] col;

   assign total = CntW'(wid_ff) * CntW'(hgt_ff);
   assign lag = CntW'(rad_ff) * CntW'(wid_ff) + CntW'(wid_ff) - CntW'(1);
   assign side = {rad_ff, 1'b1};
   assign req_tready = (st_ff == ST_IDLE) && !vld_ff;
   assign accept = req_tvalid && req_tready;

   function automatic logic [RowW-1:0] ring_inc(input logic [RowW-1:0] v);
      ring_inc = (v == RowW'(RingRows - 1)) ? '0 : v + RowW'(1);
   endfunction

   sbb_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone),
      .quotient(dq));

   always_comb begin
      colx = {1'b0, ox_ff} + {6'b0, dx_ff};
      if (colx < {7'b0, rad_ff}) col = '0;
      else if (colx - {7'b0, rad_ff} > {1'b0, wid_ff} - 10'd1)
         col = ColW'(wid_ff - 9'd1);
      else col = ColW'(colx - {7'b0, rad_ff});
   end

   always_comb begin
      st_in = st_ff; icnt_in = icnt_ff; ocnt_in = ocnt_ff;
      ix_in = ix_ff; iy_in = iy_ff; irow_in = irow_ff;
      ox_in = ox_ff; oy_in = oy_ff; orow_in = orow_ff;
      dy_in = dy_ff; dx_in = dx_ff; srow_in = srow_ff; sum_in = sum_ff;
      pass_in = pass_ff; last_in = last_ff; out_in = out_ff;
      vld_in = vld_ff && !rsp_tready;
      we = 1'b0; waddr = {irow_ff, ix_ff[ColW-1:0]};
      re = 1'b0; raddr = {srow_ff, col};
      dreq = '0;
      unique case (st_ff)
         ST_IDLE: if (accept) begin
            if (req_tdata[0] == OP_DRAIN) begin
               if (icnt_ff == total && ocnt_ff < total) st_in = ST_SUM;
            end else if (icnt_ff < total) begin
               we = 1'b1;
               icnt_in = icnt_ff + CntW'(1);
               if (ix_ff == wid_ff - 9'd1) begin
                  ix_in = '0; iy_in = iy_ff + 9'd1; irow_in = ring_inc(irow_ff);
               end else ix_in = ix_ff + 9'd1;
               if (ocnt_ff < total && icnt_in >= ocnt_ff + lag + CntW'(1))
                  st_in = ST_SUM;
            end
            if (st_in == ST_SUM) begin
               pass_in = (oy_ff < 9'(rad_ff)) || (oy_ff + 9'(rad_ff) >= hgt_ff);
               srow_in = pass_in ? orow_ff
                  : ((orow_ff >= RowW'(rad_ff)) ? orow_ff - RowW'(rad_ff)
                     : orow_ff + RowW'(RingRows) - RowW'(rad_ff));
               dy_in = '0;
               dx_in = pass_in ? 4'(rad_ff) : '0;
               sum_in = '0;
            end
         end
         ST_SUM: begin
            re = 1'b1;
            if (pass_ff || (dx_ff == side - 4'd1 && dy_ff == side - 4'd1))
               st_in = ST_LAST;
            else if (dx_ff == side - 4'd1) begin
               dx_in = '0; dy_in = dy_ff + 4'd1; srow_in = ring_inc(srow_ff);
            end else dx_in = dx_ff + 4'd1;
            if (dx_ff != 4'd0 || dy_ff != 4'd0) sum_in = sum_ff + SumW'(rd_ff);
         end
         ST_LAST: begin
            sum_in = pass_ff ? SumW'(rd_ff) : sum_ff + SumW'(rd_ff);
            st_in = ST_DIV;
         end
         ST_DIV: begin
            if (pass_ff) begin
               out_in = sum_ff[7:0]; st_in = ST_OUT;
            end else if (!dreq.start && dy_ff != 4'hF) begin
               dreq.start = 1'b1; dreq.dividend = sum_ff;
               dreq.divisor = 8'(side) * 8'(side);
               dy_in = 4'hF;
            end else if (ddone) begin
               out_in = dq; st_in = ST_OUT;
            end
         end
         ST_OUT: if (!vld_ff) begin
            vld_in = 1'b1;
            last_in = (ocnt_ff + CntW'(1) == total);
            st_in = ST_IDLE;
            if (last_in) begin
               ocnt_in = '0; icnt_in = '0; ix_in = '0; iy_in = '0; irow_in = '0;
               ox_in = '0; oy_in = '0; orow_in = '0;
            end else begin
               ocnt_in = ocnt_ff + CntW'(1);
               if (ox_ff == wid_ff - 9'd1) begin
                  ox_in = '0; oy_in = oy_ff + 9'd1; orow_in = ring_inc(orow_ff);
               end else ox_in = ox_ff + 9'd1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (csr_we && csr_index != 2'd3) begin
         icnt_in = '0; ocnt_in = '0; ix_in = '0; iy_in = '0; irow_in = '0;
         ox_in = '0; oy_in = '0; orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= req_tdata[8:1];
      if (re) rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in; srow_ff <= srow_in; sum_ff <= sum_in;
      pass_ff <= pass_in; last_ff <= last_in; out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE; vld_ff <= 1'b0; dy_ff <= '0;
         icnt_ff <= '0; ocnt_ff <= '0; ix_ff <= '0; iy_ff <= '0; irow_ff <= '0;
         ox_ff <= '0; oy_ff <= '0; orow_ff <= '0;
         rad_ff <= 3'd1; wid_ff <= 9'd256; hgt_ff <= 9'd256;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in; dy_ff <= dy_in;
         icnt_ff <= icnt_in; ocnt_ff <= ocnt_in; ix_ff <= ix_in; iy_ff <= iy_in;
         irow_ff <= irow_in; ox_ff <= ox_in; oy_ff <= oy_in; orow_ff <= orow_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RADIUS: rad_ff <= csr_wdata[2:0];
               CSR_WIDTH:  wid_ff <= (csr_wdata == 9'd0) ? 9'd1
                  : (csr_wdata > 9'(MaxWidth)) ? 9'(MaxWidth) : csr_wdata;
               CSR_HEIGHT: hgt_ff <= (csr_wdata == 9'd0) ? 9'd1
                  : (csr_wdata > 9'(MaxHeight)) ? 9'(MaxHeight) : csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tlast = last_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_out_le_in: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= icnt_ff) else $error("output count ahead of input");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !rsp_tready) |=> vld_ff) else $error("result dropped");
endmodule

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sbb_pkg::*;

   // index past the register list: the block must ignore it
   localparam logic [1:0] CsrSpare  = 2'd3;
   // worst idle pause the stimulus makes on purpose is well under this
   localparam int         StallLimit = 5000;
   // settle time before a register write, longer than one full output
   localparam int         SettleCycles = 300;

   // -----------------------------------------------------------------
   // Blur predictor and result queue
   // -----------------------------------------------------------------
   class blur_scoreboard;
      logic [7:0] rows [StoreDepth];
      int unsigned in_cnt, out_cnt;
      int unsigned rad, wid, hgt;          // register values as written
      logic [8:0]  want_q [$];             // {frame_last, pixel_out}
      int          errors, checked, frames;

      function new();
         foreach (rows[i]) rows[i] = '0;
         rad = 1;
         wid = MaxWidth;
         hgt = MaxHeight;
      endfunction

      function int unsigned eff_r();
         return (rad > MaxRadius) ? MaxRadius : rad;
      endfunction

      function int unsigned eff_w();
         if (wid < 1) return 1;
         return (wid > MaxWidth) ? MaxWidth : wid;
      endfunction

      function int unsigned eff_h();
         if (hgt < 1) return 1;
         return (hgt > MaxHeight) ? MaxHeight : hgt;
      endfunction

      function int unsigned slot(int unsigned row, int unsigned col);
         return ((row % RingRows) * MaxWidth + col) % StoreDepth;
      endfunction

      // register write: a valid index aborts the frame
      function void write_reg(logic [1:0] idx, logic [8:0] val);
         case (idx)
            CSR_RADIUS: rad = val[2:0];
            CSR_WIDTH:  wid = val;
            CSR_HEIGHT: hgt = val;
            default: return;
         endcase
         in_cnt  = 0;
         out_cnt = 0;
      endfunction

      function logic [7:0] window_mean(int unsigned k);
         int unsigned w, h, r, y, x, side, acc, row, col;
         w = eff_w(); h = eff_h(); r = eff_r();
         y = k / w; x = k % w;
         side = 2 * r + 1;
         acc = 0;
         // edge rows are copied through
         if (y < r || y + r >= h) return rows[slot(y, x)];
         for (int dy = 0; dy < side; dy++) begin
            row = y + dy - r;
            for (int dx = 0; dx < side; dx++) begin
               if (x + dx < r) col = 0;
               else begin
                  col = x + dx - r;
                  if (col > w - 1) col = w - 1;
               end
               acc += rows[slot(row, col)];
            end
         end
         return 8'(acc / (side * side));
      endfunction

      function void produce(int unsigned total);
         logic last;
         last = (out_cnt + 1 == total);
         want_q.push_back({last, window_mean(out_cnt)});
         out_cnt++;
         if (last) begin
            in_cnt  = 0;
            out_cnt = 0;
            frames++;
         end
      endfunction

      function void note_item(logic op, logic [7:0] pix);
         int unsigned w, total, lag;
         w = eff_w();
         total = w * eff_h();
         lag = eff_r() * w + w - 1;
         if (op == OP_DRAIN) begin
            // drain only releases once the whole frame is in
            if (in_cnt == total && out_cnt < total) produce(total);
            return;
         end
         if (in_cnt >= total) return;      // surplus pixel
         rows[slot(in_cnt / w, in_cnt % w)] = pix;
         in_cnt++;
         if (out_cnt < total && in_cnt >= out_cnt + lag + 1) produce(total);
      endfunction

      function bit frame_full();
         return in_cnt == eff_w() * eff_h();
      endfunction

      task report(string what);
         $display("%0t ns mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_pixel(logic [7:0] pix, logic last);
         logic [8:0] want;
         if (want_q.size() == 0) begin
            report($sformatf("unexpected item pixel=%0d last=%0b", pix, last));
            return;
         end
         want = want_q.pop_front();
         checked++;
         if (pix !== want[7:0])
            report($sformatf("pixel_out got %0d want %0d", pix, want[7:0]));
         if (last !== want[8])
            report($sformatf("frame_last got %0b want %0b", last, want[8]));
      endtask
   endclass

   // -----------------------------------------------------------------
   // DUT and signals
   // -----------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // opcode, pixel_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // pixel_out
   logic        rsp_tlast;        // frame_last
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_wdata = '0;

   separable_box_blur_8bit uut (.*);

   blur_scoreboard sb = new();
   bit quiet;            // no idling on either side
   int hold_left;        // receiver hold-off, in cycles
   int sent;

   initial begin
      forever #1 clock = ~clock;
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_item(req_tdata[0], req_tdata[8:1]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pixel(rsp_tdata, rsp_tlast);
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 27);
      end
   end

   // watchdog on cycles without any accepted item
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= StallLimit) begin
            $display("timeout after %0d idle cycles", idle);
            $display("tb_top failed");
            $finish;
         end
      end
   end

   // -----------------------------------------------------------------
   // Drive tasks (called at a falling edge, return at a falling edge)
   // -----------------------------------------------------------------
   task send_item(logic op, logic [7:0] pix);
      if (!quiet && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, pix, op};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
      sent++;
   endtask

   // let every result out and the block finish its last write
   task settle();
      req_tvalid <= 1'b0;
      while (sb.want_q.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [8:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task set_frame(logic [8:0] r, logic [8:0] w, logic [8:0] h);
      settle();
      // upper bits of the radius item are don't-care for the block
      write_reg(CSR_RADIUS, {6'($urandom_range(63)), r[2:0]});
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   // one frame of mostly well-formed traffic; abort_at > 0 cuts it short
   task run_frame(int abort_at);
      int n, start;
      logic op;
      n = 0;
      start = sb.frames;
      while (sb.frames == start) begin
         if (abort_at > 0 && n >= abort_at) break;
         if (sb.frame_full()) op = ($urandom_range(99) < 90) ? OP_DRAIN : OP_PIXEL;
         else                 op = ($urandom_range(99) < 92) ? OP_PIXEL : OP_DRAIN;
         send_item(op, 8'($urandom_range(255)));
         n++;
      end
   endtask

   // -----------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------
   initial begin
      int ph, w, h;
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: 256x256, r=1; a few items, an early drain, then an ignored spare-index write
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_DRAIN, 8'd0);
      send_item(OP_PIXEL, 8'd0);
      settle();
      write_reg(CsrSpare, 9'h1ff);

      // single pixel frame, no blur
      set_frame(9'd0, 9'd1, 9'd1);
      send_item(OP_PIXEL, 8'd255);

      // width 0 saturates to 1; r=1 over two rows: copy-through, surplus, drain
      set_frame(9'd1, 9'd0, 9'd2);
      send_item(OP_DRAIN, 8'hff);
      send_item(OP_PIXEL, 8'd255);
      send_item(OP_PIXEL, 8'd0);
      send_item(OP_PIXEL, 8'd77);
      send_item(OP_DRAIN, 8'h00);
      send_item(OP_DRAIN, 8'h00);

      // widest row, radius 7: every row copied through
      set_frame(9'd7, 9'd300, 9'd1);
      run_frame(0);
      // tall narrow frame, one column, radius 7: clamped columns everywhere
      set_frame(9'd7, 9'd1, 9'd24);
      run_frame(0);

      ph = 0;
      while (ph < 2) begin
         w = ($urandom_range(99) < 5) ? 0 : $urandom_range(12, 1);
         h = ($urandom_range(99) < 5) ? $urandom_range(511, 257) % 17 : $urandom_range(16, 1);
         set_frame(9'($urandom_range(7)), 9'(w), 9'(h));
         quiet = (ph == 1);
         // block fills and back-pressures the sender
         if (ph == 0) hold_left = 400;
         if ($urandom_range(99) < 10) run_frame($urandom_range(20, 1));
         else run_frame(0);
         ph++;
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      $display("covered %0d input items over %0d settings, %0d frames complete",
               sent, ph + 5, sb.frames);
      $display("%0d result items checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/sbb_pkg.sv
rtl/core/sbb_div.sv
rtl/core/separable_box_blur_8bit.sv
tb/tb_top.sv
